### rtl/core/lbp_pkg.sv
package lbp_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int OWNER_BITS = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int COUNT_W    = $clog2(NUM_SLOTS + 1);
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic [COUNT_W-1:0] SLOTS_ENABLED_RST = COUNT_W'(64);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_LOCK   = 2'd1,
    KIND_UNLOCK = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_SLOT  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

### rtl/core/lbp_ram.sv
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lru_block_pool_with_pinning.sv
// An accepted item is held in kind_r, idx_r and tag_r and worked on in EXEC;
// its result is then registered onto the out_ ports, marked by out_valid for
// exactly one cycle. busy is high in EXEC, the state after acceptance, while
// the link RAMs are read and then written back; no new item is taken while busy.
// Reset (synchronous, rst_n low): list empty, no slot in use, slots_enabled 64.
// The owner and link RAMs need no clearing; they are only read after a write.
module lru_block_pool_with_pinning (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbp_pkg::APB_AW-1:0]     paddr,
  input  logic [lbp_pkg::APB_DW-1:0]     pwdata,
  output logic [lbp_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic [lbp_pkg::KIND_W-1:0]     in_kind,
  input  logic [lbp_pkg::SLOT_W-1:0]     in_slot_index,
  input  logic [lbp_pkg::OWNER_BITS-1:0] in_owner_tag,
  output logic                           out_valid,
  output logic [lbp_pkg::SLOT_W-1:0]     out_granted_slot,
  output logic                           out_evicted,
  output logic [lbp_pkg::OWNER_BITS-1:0] out_victim_owner,
  output logic [lbp_pkg::STATUS_W-1:0]   out_status,
  output logic [lbp_pkg::COUNT_W-1:0]    out_slots_in_use
);

  import lbp_pkg::*;

  state_t                state_r, state_nxt;
  logic [COUNT_W-1:0]    slots_enabled_r;
  logic [KIND_W-1:0]     kind_r;
  logic [SLOT_W-1:0]     idx_r;
  logic [OWNER_BITS-1:0] tag_r;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [SLOT_W-1:0]     tail_r, tail_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COUNT_W-1:0]    used_r, used_nxt;
  logic [NUM_SLOTS-1:0]  listed_r, listed_nxt;

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     granted_r;
  logic                  evicted_r;
  logic [OWNER_BITS-1:0] victim_r;
  logic [STATUS_W-1:0]   status_r;
  logic [COUNT_W-1:0]    in_use_r;

  logic [SLOT_W-1:0]     granted_nxt;
  logic                  evicted_nxt;
  logic [OWNER_BITS-1:0] victim_nxt;
  status_t               status_nxt;

  logic                  accept;
  logic                  cfg_write;
  logic [SLOT_W-1:0]     rd_addr;
  logic [OWNER_BITS-1:0] owner_rd;
  logic [SLOT_W-1:0]     next_rd;
  logic [SLOT_W-1:0]     prev_rd;

  logic                  own_we;
  logic [SLOT_W-1:0]     own_waddr;
  logic                  nx_we;
  logic [SLOT_W-1:0]     nx_waddr;
  logic [SLOT_W-1:0]     nx_wdata;
  logic                  pv_we;
  logic [SLOT_W-1:0]     pv_waddr;
  logic [SLOT_W-1:0]     pv_wdata;

  logic                  do_remove;
  logic                  do_push;
  logic [SLOT_W-1:0]     rm_slot;
  logic [COUNT_W-1:0]    limit;
  logic                  idx_handed_out;
  logic [COUNT_W-1:0]    count_dec;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = {{(APB_DW-COUNT_W){1'b0}}, slots_enabled_r};

  // Evictions work on the tail, lock and unlock on the named slot.
  assign rd_addr = (kind_t'(in_kind) == KIND_ALLOC) ? tail_r : in_slot_index;

  lbp_ram #(.WIDTH(OWNER_BITS), .DEPTH(NUM_SLOTS)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (tag_r),
    .raddr (rd_addr),
    .rdata (owner_rd)
  );

  lbp_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  lbp_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r == ST_EXEC);

  assign limit = (slots_enabled_r > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
                                                         : slots_enabled_r;
  assign idx_handed_out = {1'b0, idx_r} < used_r;
  assign count_dec      = (count_r != '0) ? count_r - 1'b1 : count_r;

  // Decide the request and its result, then apply the list update.
  always_comb begin
    granted_nxt = idx_r;
    evicted_nxt = 1'b0;
    victim_nxt  = '0;
    status_nxt  = STAT_OK;
    used_nxt    = used_r;
    own_we      = 1'b0;
    own_waddr   = tail_r;
    do_remove   = 1'b0;
    do_push     = 1'b0;
    rm_slot     = idx_r;

    if (state_r == ST_EXEC) begin
      unique case (kind_t'(kind_r))
        KIND_ALLOC: begin
          if (used_r < limit) begin
            granted_nxt = used_r[SLOT_W-1:0];
            own_we      = 1'b1;
            own_waddr   = used_r[SLOT_W-1:0];
            used_nxt    = used_r + 1'b1;
          end else if (count_r == '0) begin
            granted_nxt = '0;
            status_nxt  = STAT_EXHAUSTED;
          end else begin
            granted_nxt = tail_r;
            evicted_nxt = 1'b1;
            victim_nxt  = owner_rd;
            own_we      = 1'b1;
            own_waddr   = tail_r;
            do_remove   = 1'b1;
            rm_slot     = tail_r;
          end
        end
        KIND_LOCK: begin
          if (idx_handed_out && listed_r[idx_r]) do_remove = 1'b1;
          else status_nxt = STAT_BAD_SLOT;
        end
        KIND_UNLOCK: begin
          if (idx_handed_out && !listed_r[idx_r]) do_push = 1'b1;
          else status_nxt = STAT_BAD_SLOT;
        end
        default: status_nxt = STAT_BAD_SLOT;
      endcase
    end
  end

  // The prev link of the head is never used, so a push leaves it as it is.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    listed_nxt = listed_r;
    nx_we      = 1'b0;
    nx_waddr   = prev_rd;
    nx_wdata   = next_rd;
    pv_we      = 1'b0;
    pv_waddr   = next_rd;
    pv_wdata   = prev_rd;

    if (do_remove) begin
      if (rm_slot == head_r) head_nxt = next_rd;
      else nx_we = 1'b1;
      if (rm_slot == tail_r) tail_nxt = prev_rd;
      else pv_we = 1'b1;
      count_nxt = count_dec;
      if (count_dec == '0) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
      listed_nxt[rm_slot] = 1'b0;
    end else if (do_push) begin
      nx_we    = 1'b1;
      nx_waddr = idx_r;
      nx_wdata = head_r;
      if (count_r == '0) begin
        tail_nxt = idx_r;
      end else begin
        pv_we    = 1'b1;
        pv_waddr = head_r;
        pv_wdata = idx_r;
      end
      head_nxt  = idx_r;
      count_nxt = count_r + 1'b1;
      listed_nxt[idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      slots_enabled_r <= SLOTS_ENABLED_RST;
      head_r          <= '0;
      tail_r          <= '0;
      count_r         <= '0;
      used_r          <= '0;
      listed_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= accept ? ST_EXEC : state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      listed_r    <= listed_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (cfg_write) begin
        slots_enabled_r <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      idx_r  <= in_slot_index;
      tag_r  <= in_owner_tag;
    end
    if (state_r == ST_EXEC) begin
      granted_r <= granted_nxt;
      evicted_r <= evicted_nxt;
      victim_r  <= victim_nxt;
      status_r  <= status_nxt;
      in_use_r  <= used_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = granted_r;
  assign out_evicted      = evicted_r;
  assign out_victim_owner = victim_r;
  assign out_status       = status_r;
  assign out_slots_in_use = in_use_r;

endmodule

### rtl/core/lbp_checker.sv
module lbp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [lbp_pkg::SLOT_W-1:0]     out_granted_slot,
  input logic                           out_evicted,
  input logic [lbp_pkg::OWNER_BITS-1:0] out_victim_owner,
  input logic [lbp_pkg::STATUS_W-1:0]   out_status,
  input logic [lbp_pkg::COUNT_W-1:0]    out_slots_in_use
);

  import lbp_pkg::*;

  // Every accepted item raises busy in the cycle after acceptance.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // The result follows the work cycle, and the block is free again by then.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("no result after the work cycle");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item");

  // An eviction always succeeds, and an exhausted pool grants nothing.
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_status == STAT_OK)
    else $error("eviction reported with a failure status");

  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EXHAUSTED |->
      out_granted_slot == '0 && !out_evicted && out_victim_owner == '0 &&
      out_slots_in_use <= COUNT_W'(NUM_SLOTS))
    else $error("exhausted result carries a grant");

endmodule

bind lru_block_pool_with_pinning lbp_checker u_lbp_checker (.*);

### test/tb_lru_block_pool_with_pinning.sv
module tb_lru_block_pool_with_pinning;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_SLOTS_ENABLED = '0;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 90;
  localparam int LIMIT_STEPS [7] = '{7, 1, 40, 127, 0, 64, 3};

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic                  evicted;
    logic [OWNER_BITS-1:0] victim;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    in_use;
  } pool_result_t;

  // Tracks the slot pool as the block should see it and holds the results
  // still owed by the block.
  class pool_tracker;
    logic [OWNER_BITS-1:0] owner_of [NUM_SLOTS];
    logic [SLOT_W-1:0]     link_next [NUM_SLOTS];
    logic [SLOT_W-1:0]     link_prev [NUM_SLOTS];
    bit                    listed [NUM_SLOTS];
    int                    head, tail, list_len, used, limit_reg;
    pool_result_t          owed_results [$];
    int                    errors;

    function void clear();
      foreach (listed[i]) listed[i] = 0;
      head = 0;
      tail = 0;
      list_len = 0;
      used = 0;
      limit_reg = 64;
      errors = 0;
    endfunction

    function void set_limit(logic [APB_DW-1:0] v);
      limit_reg = int'(v[COUNT_W-1:0]);
    endfunction

    function void unlink(int s);
      int p, n;
      p = link_prev[s];
      n = link_next[s];
      if (s == head) head = n; else link_next[p] = SLOT_W'(n);
      if (s == tail) tail = p; else link_prev[n] = SLOT_W'(p);
      if (list_len > 0) list_len--;
      if (list_len == 0) begin
        head = 0;
        tail = 0;
      end
      listed[s] = 0;
    endfunction

    function void push_head(int s);
      link_next[s] = SLOT_W'(head);
      link_prev[s] = '0;
      if (list_len == 0) tail = s; else link_prev[head] = SLOT_W'(s);
      head = s;
      list_len++;
      listed[s] = 1;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] idx,
                               logic [OWNER_BITS-1:0] tag);
      pool_result_t r;
      int cap, s;
      r.slot = idx;
      r.evicted = 1'b0;
      r.victim = '0;
      r.status = STAT_OK;
      cap = (limit_reg > NUM_SLOTS) ? NUM_SLOTS : limit_reg;
      case (kind)
        KIND_ALLOC: begin
          if (used < cap) begin
            r.slot = SLOT_W'(used);
            owner_of[used] = tag;
            used++;
          end else if (list_len == 0) begin
            r.slot = '0;
            r.status = STAT_EXHAUSTED;
          end else begin
            s = tail;
            unlink(s);
            r.victim = owner_of[s];
            owner_of[s] = tag;
            r.slot = SLOT_W'(s);
            r.evicted = 1'b1;
          end
        end
        KIND_LOCK: begin
          if (int'(idx) < used && listed[idx]) unlink(int'(idx));
          else r.status = STAT_BAD_SLOT;
        end
        KIND_UNLOCK: begin
          if (int'(idx) < used && !listed[idx]) push_head(int'(idx));
          else r.status = STAT_BAD_SLOT;
        end
        default: r.status = STAT_BAD_SLOT;
      endcase
      r.in_use = COUNT_W'(used);
      owed_results.push_back(r);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (owed_results.size() == 0) begin
        fail($sformatf("result with nothing owed: slot %0d status %0d",
                       got.slot, got.status));
        return;
      end
      want = owed_results.pop_front();
      if (got.slot !== want.slot || got.evicted !== want.evicted ||
          got.victim !== want.victim || got.status !== want.status ||
          got.in_use !== want.in_use)
        fail($sformatf({"result mismatch: expected slot %0d evicted %0d victim %h ",
                        "status %0d in_use %0d, got slot %0d evicted %0d victim %h ",
                        "status %0d in_use %0d"},
                       want.slot, want.evicted, want.victim, want.status, want.in_use,
                       got.slot, got.evicted, got.victim, got.status, got.in_use));
    endfunction

    function void check_readback(logic [APB_DW-1:0] got);
      logic [APB_DW-1:0] want;
      want = APB_DW'(limit_reg);
      if (got !== want)
        fail($sformatf("slots_enabled readback: expected %0d, got %0d", want, got));
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [SLOT_W-1:0]     in_slot_index = '0;
  logic [OWNER_BITS-1:0] in_owner_tag = '0;
  logic                  out_valid;
  logic [SLOT_W-1:0]     out_granted_slot;
  logic                  out_evicted;
  logic [OWNER_BITS-1:0] out_victim_owner;
  logic [STATUS_W-1:0]   out_status;
  logic [COUNT_W-1:0]    out_slots_in_use;

  pool_tracker pool;
  int          cycles = 0;

  lru_block_pool_with_pinning u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .in_owner_tag     (in_owner_tag),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_victim_owner (out_victim_owner),
    .out_status       (out_status),
    .out_slots_in_use (out_slots_in_use)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      pool.check_result({out_granted_slot, out_evicted, out_victim_owner,
                         out_status, out_slots_in_use});
  end

  function automatic int pick_gap(int n);
    int r;
    // Every fourth stretch of 16 items runs back to back.
    if (n % 64 < 16) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Returns a random handed-out slot that is (or is not) in the recency list,
  // or -1 when there is none.
  function automatic int pick_slot(bit want_listed);
    int cand [$];
    for (int i = 0; i < pool.used; i++)
      if (pool.listed[i] == want_listed) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic issue(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] idx,
                       input logic [OWNER_BITS-1:0] tag, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_slot_index <= idx;
    in_owner_tag <= tag;
    do @(posedge clk); while (busy);
    pool.note_request(kind, idx, tag);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pool.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word = {word[APB_DW-1:COUNT_W], COUNT_W'(v)};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SLOTS_ENABLED;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pool.set_limit(word);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pool.check_readback(prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int r, s;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] idx;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      idx = SLOT_W'($urandom());
      if (r < 36) begin
        kind = KIND_ALLOC;
      end else if (r < 66) begin
        kind = KIND_UNLOCK;
        s = pick_slot(1'b0);
        if (s >= 0 && $urandom_range(0, 99) < 85) idx = SLOT_W'(s);
      end else if (r < 92) begin
        kind = KIND_LOCK;
        s = pick_slot(1'b1);
        if (s >= 0 && $urandom_range(0, 99) < 85) idx = SLOT_W'(s);
      end else begin
        // Noise: any kind, the reserved code included, on any slot.
        kind = KIND_W'($urandom_range(0, 3));
      end
      issue(kind, idx, OWNER_BITS'($urandom()), pick_gap(n));
    end
  endtask

  initial begin
    pool = new();
    pool.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Limit zero with nothing in use: allocate finds the pool exhausted.
    write_limit(0);
    @(posedge clk);
    issue(KIND_ALLOC, 6'd5, 16'h5a5a, 0);
    issue(KIND_LOCK, 6'd0, 16'h0000, 0);
    issue(KIND_UNLOCK, 6'd63, 16'hffff, 0);
    issue(KIND_RSVD, 6'd63, 16'hffff, 0);
    drain();

    write_limit(2);
    @(posedge clk);
    issue(KIND_ALLOC, 6'd63, 16'hffff, 0);
    issue(KIND_ALLOC, 6'd0, 16'h0000, 0);
    issue(KIND_ALLOC, 6'd0, 16'h7777, 0);   // all locked
    issue(KIND_UNLOCK, 6'd0, 16'h0000, 1);
    issue(KIND_UNLOCK, 6'd0, 16'h0000, 0);  // already listed
    issue(KIND_LOCK, 6'd1, 16'h0000, 2);    // not listed
    issue(KIND_UNLOCK, 6'd1, 16'h0000, 0);
    issue(KIND_ALLOC, 6'd0, 16'h1234, 0);   // evicts slot 0
    issue(KIND_LOCK, 6'd1, 16'h0000, 0);    // sole entry
    issue(KIND_UNLOCK, 6'd0, 16'h0000, 3);
    issue(KIND_UNLOCK, 6'd1, 16'h0000, 0);
    issue(KIND_LOCK, 6'd0, 16'h0000, 0);    // tail
    issue(KIND_UNLOCK, 6'd0, 16'h0000, 0);
    issue(KIND_LOCK, 6'd0, 16'h0000, 1);    // head
    issue(KIND_ALLOC, 6'd0, 16'habcd, 0);   // evicts slot 1
    issue(KIND_UNLOCK, 6'd2, 16'h0000, 0);  // never handed out
    issue(KIND_LOCK, 6'd63, 16'h0000, 0);
    drain();

    // Settings in turn: growth, a lowered limit, growth, out of range, zero, full, a lowered limit.
    foreach (LIMIT_STEPS[i]) begin
      write_limit(LIMIT_STEPS[i]);
      @(posedge clk);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (pool.pending() != 0) pool.fail("results still owed at the end");
    if (pool.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
